### hw/rtl/bsg_pkg.sv
`default_nettype none
package bsg_pkg;

  // Arithmetic word width and field widths.
  localparam int DATA_W = 32;
  localparam int ADC_W = 25;
  localparam int VOLT_W = 23;
  localparam int CAP_W = 10;
  localparam int ENTRY_W = VOLT_W + CAP_W;

  // Parameter defaults.
  localparam int CURVE_DEPTH_DEF = 32;
  localparam int AVG_SHIFT_DEF = 4;

  // Built-in discharge curve and limits.
  localparam int DEFAULT_POINTS = 15;
  localparam logic [VOLT_W-1:0] V_MIN_OK = 23'd3000000;
  localparam logic [VOLT_W-1:0] V_MAX_OK = 23'd4500000;
  localparam logic [CAP_W-1:0] CAP_MAX_OK = 10'd1000;
  localparam logic [DATA_W-1:0] SNAP_LIMIT = 32'd1000000;
  localparam logic [6:0] EMPTY_PCT = 7'd100;

  // Reciprocal of ten for a multiply-and-shift division, exact for 32-bit values.
  localparam logic [63:0] RECIP10 = 64'hCCCC_CCCD;
  localparam int RECIP10_SHIFT = 35;

  // Configuration register reset values.
  localparam logic [12:0] ADC_SCALE_RST = 13'd1129;
  localparam logic [15:0] HYST_RST = 16'd4000;
  localparam logic [15:0] RESID_RST = 16'd1000;
  localparam logic [17:0] CHG_OFS_RST = 18'd90000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ADC_SCALE = 2'd0,
    CFG_HYSTERESIS = 2'd1,
    CFG_RESIDUAL = 2'd2,
    CFG_CHG_OFFSET = 2'd3
  } cfg_idx_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_HELD = 2'd1,
    ST_WR_OK = 2'd2,
    ST_WR_REJ = 2'd3
  } status_t;

  // One curve entry as stored: voltage over capacity.
  typedef struct packed {
    logic [VOLT_W-1:0] volt;
    logic [CAP_W-1:0] cap;
  } entry_t;

  // Entry of the built-in curve at a position; zero past its end.
  function automatic entry_t default_entry(input logic [7:0] i);
    entry_t e;
    e = '0;
    case (i)
      8'd0: e = '{23'd4050000, 10'd1000};
      8'd1: e = '{23'd3979000, 10'd917};
      8'd2: e = '{23'd3905000, 10'd829};
      8'd3: e = '{23'd3852000, 10'd759};
      8'd4: e = '{23'd3808000, 10'd689};
      8'd5: e = '{23'd3768000, 10'd620};
      8'd6: e = '{23'd3736000, 10'd551};
      8'd7: e = '{23'd3710000, 10'd482};
      8'd8: e = '{23'd3686000, 10'd420};
      8'd9: e = '{23'd3668000, 10'd363};
      8'd10: e = '{23'd3652000, 10'd300};
      8'd11: e = '{23'd3637000, 10'd243};
      8'd12: e = '{23'd3600000, 10'd180};
      8'd13: e = '{23'd3572000, 10'd95};
      8'd14: e = '{23'd3500000, 10'd0};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/bsg_if.sv
`default_nettype none
// Input item channel.
interface bsg_req_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [11:0] adc_code;
  logic is_charging;
  logic [4:0] table_index;
  logic [22:0] entry_voltage_uv;
  logic [9:0] entry_capacity;
  modport source(output valid, cmd, adc_code, is_charging, table_index,
                 entry_voltage_uv, entry_capacity, input ready);
  modport sink(input valid, cmd, adc_code, is_charging, table_index,
               entry_voltage_uv, entry_capacity, output ready);
endinterface

// Result item channel.
interface bsg_rsp_if;
  logic valid;
  logic ready;
  logic [24:0] voltage_uv;
  logic [6:0] capacity_pct;
  logic [1:0] status;
  modport source(output valid, voltage_uv, capacity_pct, status, input ready);
  modport sink(input valid, voltage_uv, capacity_pct, status, output ready);
endinterface
`default_nettype wire

### hw/rtl/bsg_curve_mem.sv
`default_nettype none
module bsg_curve_mem
  import bsg_pkg::*;
#(
  parameter int DEPTH = CURVE_DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic we,
  input wire logic [IDX_W-1:0] waddr,
  input wire entry_t wdata,
  input wire logic [IDX_W-1:0] raddr,
  output entry_t rdata
);

  entry_t mem [DEPTH];
  logic [DEPTH-1:0] vld;
  entry_t mem_q;
  logic vld_q;
  logic [IDX_W-1:0] raddr_q;

  // Storage array with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
    raddr_q <= raddr;
  end

  // Written flags; an unwritten entry reads as the built-in curve.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      vld_q <= vld[raddr];
    end
  end

  assign rdata = vld_q ? mem_q : default_entry(8'(raddr_q));

endmodule
`default_nettype wire

### hw/rtl/bsg_div.sv
`default_nettype none
module bsg_div
  import bsg_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [DATA_W-1:0] dividend,
  input wire logic [DATA_W-1:0] divisor,
  output logic done,
  output logic [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0] rem;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic [DATA_W:0] rem_sh;
  logic fits;

  // One quotient bit per cycle, restoring.
  assign rem_sh = {rem[DATA_W-1:0], quotient[DATA_W-1]};
  assign fits = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      rem <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
      quotient <= {quotient[DATA_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(DATA_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/battery_soc_gauge_core.sv
`default_nettype none
// Battery gauge: a sample item scales the ADC code, feeds a leaky average with
// hysteresis and looks the reported voltage (less an offset while charging) up
// in a descending discharge curve held in a one-port-read synchronous memory,
// interpolating to a percent. A write item edits that curve. One item is worked
// at a time, and the input is ready again in the same cycle that a result is
// presented. A sample held while settling skips the lookup, as does a sample
// that needs no new lookup; a lookup steps over curve entries, and interpolation
// may run the bit-serial 32-bit divider. A write sweeps the curve entries it
// affects. A result that is not taken holds the next item in its last step
// until it is.
module battery_soc_gauge_core
  import bsg_pkg::*;
#(
  parameter int CURVE_DEPTH = CURVE_DEPTH_DEF,
  parameter int AVG_SHIFT = AVG_SHIFT_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [17:0] cfg_data,
  bsg_req_if.sink req,
  bsg_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(CURVE_DEPTH);
  localparam int LEN_W = $clog2(CURVE_DEPTH + 1);
  localparam int LEN_RST = (DEFAULT_POINTS < CURVE_DEPTH) ? DEFAULT_POINTS : CURVE_DEPTH;

  typedef enum logic [18:0] {
    S_IDLE   = 19'd1 << 0,
    S_MUL    = 19'd1 << 1,
    S_AVG    = 19'd1 << 2,
    S_HYS    = 19'd1 << 3,
    S_SNAP   = 19'd1 << 4,
    S_LEVEL  = 19'd1 << 5,
    S_DN_RD  = 19'd1 << 6,
    S_DN_CK  = 19'd1 << 7,
    S_UP_RD  = 19'd1 << 8,
    S_UP_CK  = 19'd1 << 9,
    S_P_RD   = 19'd1 << 10,
    S_N_RD   = 19'd1 << 11,
    S_INTERP = 19'd1 << 12,
    S_DSTART = 19'd1 << 13,
    S_DIV    = 19'd1 << 14,
    S_DIV10  = 19'd1 << 15,
    S_WRCHK  = 19'd1 << 16,
    S_SWEEP  = 19'd1 << 17,
    S_DONE   = 19'd1 << 18
  } state_t;

  state_t st;

  // Configuration registers.
  logic [12:0] adc_scale;
  logic [15:0] hysteresis_uv;
  logic [15:0] residual_step_uv;
  logic [17:0] charge_offset_uv;

  // Latched item.
  logic [11:0] code_q;
  logic chg_q;
  logic [4:0] idx_q;
  logic [VOLT_W-1:0] ev_q;
  logic [CAP_W-1:0] ec_q;

  // Gauge state.
  logic [DATA_W-1:0] rsum;
  logic [DATA_W-1:0] rv;
  logic [6:0] rc;
  logic [LEN_W-1:0] len;
  logic [IDX_W-1:0] pos;
  logic [1:0] init_cnt;
  logic [2:0] settle;
  logic last_chg;

  // Working registers.
  logic [ADC_W-1:0] adc;
  logic [DATA_W-1:0] avg_q;
  logic up_q;
  logic [DATA_W-1:0] level;
  logic [IDX_W-1:0] p;
  logic [IDX_W-1:0] lastp;
  entry_t ent_p;
  logic [DATA_W-1:0] span;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] tval;
  status_t status_q;
  logic [IDX_W-1:0] wp;
  logic [IDX_W-1:0] wend;
  entry_t wdata;

  // Memory and divider hookup.
  logic mem_we;
  logic [IDX_W-1:0] mem_raddr;
  entry_t mem_rdata;
  logic div_done;
  logic [DATA_W-1:0] div_q;

  // Combinational helpers.
  logic chg_event;
  logic [2:0] settle_eff;
  logic [1:0] init_eff;
  logic [DATA_W-1:0] sum_next;
  logic [DATA_W-1:0] avg;
  logic up;
  logic [DATA_W-1:0] diff;
  logic [DATA_W-1:0] step;
  logic [DATA_W-1:0] diff2;
  logic [DATA_W-1:0] cdiff;
  logic [63:0] q10;
  logic wr_bad;

  bsg_curve_mem #(
    .DEPTH(CURVE_DEPTH),
    .IDX_W(IDX_W)
  ) u_mem (
    .clk(clk),
    .rst(rst),
    .we(mem_we),
    .waddr(wp),
    .wdata(wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  bsg_div u_div (
    .clk(clk),
    .rst(rst),
    .start(st == S_DSTART),
    .dividend(prod),
    .divisor(span),
    .done(div_done),
    .quotient(div_q)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      adc_scale <= ADC_SCALE_RST;
      hysteresis_uv <= HYST_RST;
      residual_step_uv <= RESID_RST;
      charge_offset_uv <= CHG_OFS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ADC_SCALE: adc_scale <= cfg_data[12:0];
        CFG_HYSTERESIS: hysteresis_uv <= cfg_data[15:0];
        CFG_RESIDUAL: residual_step_uv <= cfg_data[15:0];
        CFG_CHG_OFFSET: charge_offset_uv <= cfg_data;
        default: ;
      endcase
    end
  end

  assign req.ready = (st == S_IDLE);

  // Settling and averaging arithmetic.
  assign chg_event = (init_cnt == 2'd0) && (last_chg != chg_q);
  assign settle_eff = chg_event ? 3'd4 : settle;
  assign init_eff = (settle_eff == 3'd1) ? 2'd1 : init_cnt;
  assign sum_next = rsum - (rsum >> AVG_SHIFT) + DATA_W'(adc);
  assign avg = rsum >> AVG_SHIFT;
  assign up = avg > rv;
  assign diff = up ? avg - rv : rv - avg;
  assign step = diff - DATA_W'(hysteresis_uv) + DATA_W'(residual_step_uv);
  assign diff2 = up_q ? avg_q - rv : rv - avg_q;
  assign cdiff = DATA_W'(ent_p.cap) - DATA_W'(mem_rdata.cap);
  assign q10 = 64'(tval) * RECIP10;
  assign wr_bad = (32'(idx_q) >= 32'(CURVE_DEPTH)) || (ec_q > CAP_MAX_OK) ||
                  ((ev_q != '0) && ((ev_q < V_MIN_OK) || (ev_q > V_MAX_OK)));

  // Memory port use per step.
  always_comb begin
    mem_we = (st == S_SWEEP);
    case (st)
      S_UP_RD: mem_raddr = p + 1'b1;
      S_N_RD: mem_raddr = (p == lastp) ? p : p + 1'b1;
      default: mem_raddr = p;
    endcase
  end

  // Item sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      rsum <= '0;
      rv <= '0;
      rc <= '0;
      len <= LEN_W'(LEN_RST);
      pos <= '0;
      init_cnt <= 2'd2;
      settle <= '0;
      last_chg <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && (st != S_DONE)) begin
        rsp.valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (req.valid) begin
            code_q <= req.adc_code;
            chg_q <= req.is_charging;
            idx_q <= req.table_index;
            ev_q <= req.entry_voltage_uv;
            ec_q <= req.entry_capacity;
            st <= req.cmd ? S_WRCHK : S_MUL;
          end
        end
        S_MUL: begin
          adc <= ADC_W'(code_q) * ADC_W'(adc_scale);
          st <= S_AVG;
        end
        S_AVG: begin
          if (chg_event) begin
            last_chg <= chg_q;
          end
          if (settle_eff > 3'd1) begin
            settle <= settle_eff - 3'd1;
            status_q <= ST_HELD;
            st <= S_DONE;
          end else begin
            status_q <= ST_UPDATED;
            settle <= '0;
            if (init_eff != 2'd0) begin
              init_cnt <= init_eff - 2'd1;
              rsum <= DATA_W'(adc) << AVG_SHIFT;
              rv <= DATA_W'(adc);
              pos <= '0;
              rc <= '0;
              if (!chg_event) begin
                last_chg <= chg_q;
              end
              st <= S_LEVEL;
            end else begin
              rsum <= sum_next;
              st <= S_HYS;
            end
          end
        end
        S_HYS: begin
          avg_q <= avg;
          up_q <= up;
          if (diff > DATA_W'(hysteresis_uv)) begin
            rv <= up ? rv + step : rv - step;
            rc <= '0;
            st <= S_SNAP;
          end else begin
            st <= S_LEVEL;
          end
        end
        S_SNAP: begin
          if (diff2 > SNAP_LIMIT) begin
            rv <= avg_q;
          end
          st <= S_LEVEL;
        end
        S_LEVEL: begin
          level <= rv - (chg_q ? DATA_W'(charge_offset_uv) : '0);
          lastp <= IDX_W'(len - 1'b1);
          p <= (32'(pos) > 32'(len) - 32'd1) ? '0 : pos;
          if (len == '0) begin
            rc <= EMPTY_PCT;
            st <= S_DONE;
          end else if (rc != '0) begin
            st <= S_DONE;
          end else begin
            st <= S_DN_RD;
          end
        end
        // Walk toward the top of the curve while above the entry.
        S_DN_RD: st <= S_DN_CK;
        S_DN_CK: begin
          if ((p != '0) && (level > DATA_W'(mem_rdata.volt))) begin
            p <= p - 1'b1;
            st <= S_DN_RD;
          end else begin
            st <= S_UP_RD;
          end
        end
        // Walk down the curve while at or below the next entry.
        S_UP_RD: st <= (p == lastp) ? S_P_RD : S_UP_CK;
        S_UP_CK: begin
          if (level <= DATA_W'(mem_rdata.volt)) begin
            p <= p + 1'b1;
            st <= S_UP_RD;
          end else begin
            st <= S_P_RD;
          end
        end
        S_P_RD: st <= S_N_RD;
        S_N_RD: begin
          ent_p <= mem_rdata;
          st <= S_INTERP;
        end
        // Pick the bracket result or set up the interpolation.
        S_INTERP: begin
          span <= DATA_W'(ent_p.volt) - DATA_W'(mem_rdata.volt);
          prod <= DATA_W'((level - DATA_W'(mem_rdata.volt)) * cdiff);
          wdata <= mem_rdata;
          if ((level > DATA_W'(ent_p.volt)) || (p == lastp)) begin
            tval <= DATA_W'(ent_p.cap);
            st <= S_DIV10;
          end else if (ent_p.volt == mem_rdata.volt) begin
            tval <= DATA_W'(mem_rdata.cap);
            st <= S_DIV10;
          end else begin
            st <= S_DSTART;
          end
        end
        S_DSTART: st <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            tval <= div_q + DATA_W'(wdata.cap);
            st <= S_DIV10;
          end
        end
        S_DIV10: begin
          rc <= q10[RECIP10_SHIFT +: 7];
          pos <= p;
          st <= S_DONE;
        end
        // Curve edit: check, then sweep the affected entries.
        S_WRCHK: begin
          if (wr_bad) begin
            status_q <= ST_WR_REJ;
            st <= S_DONE;
          end else begin
            status_q <= ST_WR_OK;
            pos <= '0;
            rc <= '0;
            if (ev_q == '0) begin
              wdata <= '0;
              wp <= IDX_W'(idx_q);
              wend <= IDX_W'(len - 1'b1);
              if (32'(idx_q) < 32'(len)) begin
                len <= LEN_W'(idx_q);
                st <= S_SWEEP;
              end else begin
                st <= S_DONE;
              end
            end else begin
              wdata <= '{ev_q, ec_q};
              wend <= IDX_W'(idx_q);
              if (32'(idx_q) < 32'(len)) begin
                wp <= IDX_W'(idx_q);
              end else begin
                wp <= IDX_W'(len);
                len <= LEN_W'(32'(idx_q) + 32'd1);
              end
              st <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          wp <= wp + 1'b1;
          if (wp == wend) begin
            st <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            rsp.voltage_uv <= rv[24:0];
            rsp.capacity_pct <= rc;
            rsp.status <= status_q;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (st != S_IDLE))
    else $error("accepted item did not start work");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    32'(len) <= 32'(CURVE_DEPTH))
    else $error("curve length beyond depth");
  a_settle_bound: assert property (@(posedge clk) disable iff (rst)
    settle <= 3'd3)
    else $error("settle count out of range");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(st) == S_DONE))
    else $error("result loaded outside the done step");
`endif

endmodule
`default_nettype wire
